// ===== src/wgm_pkg.sv =====
// shared types and constants of the glob matcher
package wgm_pkg;

	// field widths of the item and result channels
	localparam int unsigned ACTION_W = 2;
	localparam int unsigned INDEX_W  = 6;
	localparam int unsigned SYMBOL_W = 8;
	localparam int unsigned LENGTH_W = 7;

	// width used for length and position compares (covers pattern sizes up to 255)
	localparam int unsigned CMP_W = 8;

	// apb port
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	// register indexes, taken from paddr[2]
	localparam logic REG_IGNORE_CASE    = 1'b0;
	localparam logic REG_PATTERN_LENGTH = 1'b1;

	// register reset values
	localparam logic                IGNORE_CASE_RST    = 1'b1;
	localparam logic [LENGTH_W-1:0] PATTERN_LENGTH_RST = 7'd0;

	// item action codes
	localparam logic [ACTION_W-1:0] ACT_PATTERN = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_SUBJECT = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_END     = 2'd2;

	// special pattern bytes and ascii letter bounds
	localparam logic [SYMBOL_W-1:0] STAR_SYM    = 8'd42;
	localparam logic [SYMBOL_W-1:0] QMARK_SYM   = 8'd63;
	localparam logic [SYMBOL_W-1:0] UPPER_A     = 8'd65;
	localparam logic [SYMBOL_W-1:0] UPPER_Z     = 8'd90;
	localparam logic [SYMBOL_W-1:0] LOWER_A     = 8'd97;
	localparam logic [SYMBOL_W-1:0] LOWER_Z     = 8'd122;
	localparam logic [SYMBOL_W-1:0] CASE_OFFSET = 8'd32;

	// configuration as seen by the datapath
	typedef struct packed {
		logic                ignore_case;
		logic [LENGTH_W-1:0] pattern_length;
	} cfg_t;

	// bits one cell hands to the next position
	typedef struct packed {
		logic pre;  // closure of the held active bits through a star
		logic adv;  // a literal or '?' matched, next position becomes active
		logic post; // closure of the new active bits through a star
	} link_t;

endpackage

// ===== src/wgm_if.sv =====
// item and result channel interfaces
interface wgm_item_if;
	logic                            valid;
	logic                            ready;
	logic [wgm_pkg::ACTION_W-1:0]    action;
	logic [wgm_pkg::INDEX_W-1:0]     pattern_index;
	logic [wgm_pkg::SYMBOL_W-1:0]    symbol;

	modport source (output valid, action, pattern_index, symbol, input ready);
	modport sink   (input valid, action, pattern_index, symbol, output ready);
endinterface

interface wgm_result_if;
	logic valid;
	logic ready;
	logic matched;

	modport source (output valid, matched, input ready);
	modport sink   (input valid, matched, output ready);
endinterface

// ===== src/wgm_cfg.sv =====
// apb register file: ignore_case and pattern_length
module wgm_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [wgm_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [wgm_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [wgm_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	output wgm_pkg::cfg_t                     cfg
);

	logic                           ignore_case_q;
	logic [wgm_pkg::LENGTH_W-1:0]   pattern_length_q;
	logic                           wr;
	logic                           sel;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	assign sel    = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ignore_case_q    <= wgm_pkg::IGNORE_CASE_RST;
			pattern_length_q <= wgm_pkg::PATTERN_LENGTH_RST;
		end else if (wr) begin
			unique case (sel)
				wgm_pkg::REG_IGNORE_CASE:    ignore_case_q    <= pwdata[0];
				wgm_pkg::REG_PATTERN_LENGTH: pattern_length_q <= pwdata[wgm_pkg::LENGTH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			wgm_pkg::REG_IGNORE_CASE:    prdata = wgm_pkg::APB_DATA_W'(ignore_case_q);
			wgm_pkg::REG_PATTERN_LENGTH: prdata = wgm_pkg::APB_DATA_W'(pattern_length_q);
			default:                     prdata = '0;
		endcase
	end

	assign cfg.ignore_case    = ignore_case_q;
	assign cfg.pattern_length = pattern_length_q;

endmodule

// ===== src/wgm_cell.sv =====
// one pattern position: stored byte, active bit, match and star closure
module wgm_cell #(
	parameter bit IS_HOME = 1'b0
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [wgm_pkg::SYMBOL_W-1:0]    symbol,
	input  logic                            ignore_case,
	input  logic                            en,
	input  logic                            step,
	input  logic                            rearm,
	input  wgm_pkg::link_t                  link_in,
	output wgm_pkg::link_t                  link_out,
	output logic                            closed
);

	logic [wgm_pkg::SYMBOL_W-1:0] pat_q;
	logic                         active_q;
	logic                         is_star;
	logic                         go;
	logic                         hit;
	logic                         upper;
	logic                         lower;
	logic                         raw;
	logic                         nxt;

	// pattern byte, no reset: undefined until written
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pat_q <= symbol;
		end
	end

	assign is_star = (pat_q == wgm_pkg::STAR_SYM);
	assign go      = en && is_star;
	assign upper   = (pat_q >= wgm_pkg::UPPER_A) && (pat_q <= wgm_pkg::UPPER_Z);
	assign lower   = (pat_q >= wgm_pkg::LOWER_A) && (pat_q <= wgm_pkg::LOWER_Z);

	assign hit = (pat_q == wgm_pkg::QMARK_SYM) || (pat_q == symbol)
		|| (ignore_case && upper && ((pat_q + wgm_pkg::CASE_OFFSET) == symbol))
		|| (ignore_case && lower && ((pat_q - wgm_pkg::CASE_OFFSET) == symbol));

	// closure of the held bits, then the step, then closure of the new bits
	assign closed        = active_q || link_in.pre;
	assign link_out.pre  = closed && go;
	assign link_out.adv  = closed && en && !is_star && hit;
	assign raw           = (closed && go) || link_in.adv;
	assign nxt           = raw || link_in.post;
	assign link_out.post = nxt && go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= IS_HOME;
		end else if (rearm) begin
			active_q <= IS_HOME;
		end else if (step) begin
			active_q <= nxt;
		end
	end

endmodule

// ===== src/wildcard_glob_matcher.sv =====
// top level of the glob matcher: cell row, apb registers, result register
//
// channel   dir  transfer                         payload
// item      in   item.valid && item.ready         action, pattern_index, symbol
// result    out  result.valid && result.ready     matched
// apb       in   psel && penable && pwrite        ignore_case, pattern_length
//
// one item per cycle unless stalled; a subject byte updates all positions at once
// in the row of cells, bounded by the two ripple closure chains along the row
// an end-of-subject item loads the result register at its transfer edge,
// the result is offered from the next cycle on
// reset clears the active bits to position zero and empties the result register;
// the pattern bytes hold whatever was there until written
// item.ready drops only while a result is held and result.ready is low
module wildcard_glob_matcher #(
	parameter int unsigned PATTERN_MAX = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	wgm_item_if.sink                          item,
	wgm_result_if.source                      result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [wgm_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [wgm_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [wgm_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready
);

	localparam int unsigned SEL_W = $clog2(PATTERN_MAX + 1);

	wgm_pkg::cfg_t               cfg;
	logic [wgm_pkg::CMP_W-1:0]   len_ext;
	logic [wgm_pkg::CMP_W-1:0]   eff_len;
	logic                        accept;
	logic                        do_write;
	logic                        do_step;
	logic                        do_end;
	logic                        last_q;       // active bit of the final position
	logic                        result_valid_q;
	logic                        matched_q;
	logic [PATTERN_MAX:0]        closed;       // active bits after star closure
	wgm_pkg::link_t              links [PATTERN_MAX+1];

	// register file
	wgm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// lengths above the row size behave as the full row
	assign len_ext = wgm_pkg::CMP_W'(cfg.pattern_length);
	assign eff_len = (len_ext > wgm_pkg::CMP_W'(PATTERN_MAX))
		? wgm_pkg::CMP_W'(PATTERN_MAX) : len_ext;

	// a held result blocks new items only while the sink stalls
	assign item.ready = !result_valid_q || result.ready;
	assign accept     = item.valid && item.ready;

	always_comb begin
		do_write = 1'b0;
		do_step  = 1'b0;
		do_end   = 1'b0;
		unique case (item.action)
			wgm_pkg::ACT_PATTERN: do_write = accept;
			wgm_pkg::ACT_SUBJECT: do_step  = accept;
			wgm_pkg::ACT_END:     do_end   = accept;
			default: ;  // unused code, no effect
		endcase
	end

	// nothing flows into position zero
	assign links[0] = '0;

	// row of cells, one per pattern position
	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		logic wr_en;
		logic en;

		assign wr_en = do_write
			&& (wgm_pkg::CMP_W'(item.pattern_index) == wgm_pkg::CMP_W'(i));
		assign en    = wgm_pkg::CMP_W'(i) < eff_len;

		wgm_cell #(
			.IS_HOME (i == 0)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.wr_en       (wr_en),
			.symbol      (item.symbol),
			.ignore_case (cfg.ignore_case),
			.en          (en),
			.step        (do_step),
			.rearm       (do_end),
			.link_in     (links[i]),
			.link_out    (links[i+1]),
			.closed      (closed[i])
		);
	end

	// final position has no pattern byte, it only collects from the last cell
	assign closed[PATTERN_MAX] = last_q || links[PATTERN_MAX].pre;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
		end else if (do_end) begin
			last_q <= 1'b0;
		end else if (do_step) begin
			last_q <= links[PATTERN_MAX].adv || links[PATTERN_MAX].post;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (do_end) begin
			result_valid_q <= 1'b1;
		end else if (result.ready) begin
			result_valid_q <= 1'b0;
		end
	end

	// whole subject matched when the position after the pattern is active
	always_ff @(posedge clk) begin
		if (do_end) begin
			matched_q <= closed[eff_len[SEL_W-1:0]];
		end
	end

	assign result.valid   = result_valid_q;
	assign result.matched = matched_q;

endmodule
